/* hw/rtl/clbs_pkg.sv */
`timescale 1ns / 1ps

package clbs_pkg;

    // Request operations
    typedef enum logic [1:0] {
        OP_COMMAND = 2'd0,
        OP_DATA    = 2'd1,
        OP_INIT    = 2'd2,
        OP_CURSOR  = 2'd3
    } op_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FOUR_BIT   = 2'd0,
        CFG_LINE_COUNT = 2'd1,
        CFG_COLUMNS    = 2'd2,
        CFG_TALL_FONT  = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        K_WAIT   = 2'd0,
        K_STROBE = 2'd1,
        K_BYTE   = 2'd2
    } step_kind_t;

    typedef enum logic [2:0] {
        H_1     = 3'd0,
        H_100   = 3'd1,
        H_150   = 3'd2,
        H_2000  = 3'd3,
        H_4500  = 3'd4,
        H_50000 = 3'd5
    } hold_sel_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_RUN   = 2'd1,
        ST_EXTRA = 2'd2
    } ctrl_state_t;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] LAST_INIT_STEP_NIBBLE = 4'd11;
    localparam logic [STEP_W-1:0] LAST_INIT_STEP_BYTE   = 4'd9;

    localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] NIB_WAKE       = 8'h30;
    localparam logic [7:0] NIB_FOUR_BIT   = 8'h20;
    localparam logic [7:0] DDRAM_ADDR_CMD = 8'h80;
    localparam logic [7:0] ROW1_OFFSET    = 8'h40;

    typedef struct packed {
        step_kind_t kind;
        logic       rs;
        logic [7:0] data;
        hold_sel_t  wait_hold;
    } step_desc_t;

    // Controller to datapath
    typedef struct packed {
        logic              start;
        logic              emit;
        logic              en;
        hold_sel_t         hold;
        logic              wait_ph;
        logic              nib;
        logic              last;
        logic [STEP_W-1:0] step;
    } clbs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        step_kind_t kind;
        logic       needs_extra;
        logic       last_step;
        logic       four_bit;
        logic       out_free;
        hold_sel_t  wait_hold;
    } clbs_stat_t;

    function automatic logic [15:0] hold_value(input hold_sel_t sel);
        logic [15:0] v;
        unique case (sel)
            H_1:     v = 16'd1;
            H_100:   v = 16'd100;
            H_150:   v = 16'd150;
            H_2000:  v = 16'd2000;
            H_4500:  v = 16'd4500;
            H_50000: v = 16'd50000;
            default: v = 16'd1;
        endcase
        return v;
    endfunction

    // Power-on script, one step per index
    function automatic step_desc_t init_step(input logic [STEP_W-1:0] idx,
                                             input logic four, input logic [7:0] fs);
        step_desc_t d;
        d.kind      = K_BYTE;
        d.rs        = 1'b0;
        d.data      = fs;
        d.wait_hold = H_50000;
        if (four) begin
            unique case (idx)
                4'd0:  begin d.kind = K_WAIT;   d.wait_hold = H_50000; end
                4'd1:  begin d.kind = K_STROBE; d.data = NIB_WAKE; end
                4'd2:  begin d.kind = K_WAIT;   d.wait_hold = H_4500; end
                4'd3:  begin d.kind = K_STROBE; d.data = NIB_WAKE; end
                4'd4:  begin d.kind = K_WAIT;   d.wait_hold = H_4500; end
                4'd5:  begin d.kind = K_STROBE; d.data = NIB_WAKE; end
                4'd6:  begin d.kind = K_WAIT;   d.wait_hold = H_150; end
                4'd7:  begin d.kind = K_STROBE; d.data = NIB_FOUR_BIT; end
                4'd8:  d.data = fs;
                4'd9:  d.data = CMD_DISPLAY_ON;
                4'd10: d.data = CMD_CLEAR;
                4'd11: d.data = CMD_ENTRY_MODE;
                default: d.data = fs;
            endcase
        end else begin
            unique case (idx)
                4'd0:  begin d.kind = K_WAIT; d.wait_hold = H_50000; end
                4'd1:  d.data = fs;
                4'd2:  begin d.kind = K_WAIT; d.wait_hold = H_4500; end
                4'd3:  d.data = fs;
                4'd4:  begin d.kind = K_WAIT; d.wait_hold = H_150; end
                4'd5:  d.data = fs;
                4'd6:  d.data = fs;
                4'd7:  d.data = CMD_DISPLAY_ON;
                4'd8:  d.data = CMD_CLEAR;
                4'd9:  d.data = CMD_ENTRY_MODE;
                default: d.data = fs;
            endcase
        end
        return d;
    endfunction

endpackage

/* hw/rtl/clbs_ctrl.sv */
`timescale 1ns / 1ps

module clbs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  clbs_pkg::clbs_stat_t stat,
    output clbs_pkg::clbs_cmd_t  cmd
);

    clbs_pkg::ctrl_state_t state_reg, state_next;
    logic [clbs_pkg::STEP_W-1:0] step_reg, step_next;
    logic [1:0] sub_reg, sub_next;
    logic       nib_reg, nib_next;
    logic       step_end;
    logic       go_extra;
    logic       byte_end;

    // Outputs and step bookkeeping
    always_comb begin
        cmd         = '0;
        cmd.hold    = clbs_pkg::H_1;
        cmd.step    = step_reg;
        cmd.nib     = nib_reg;
        s_tready    = 1'b0;
        step_end    = 1'b0;
        go_extra    = 1'b0;
        byte_end    = 1'b0;
        unique case (state_reg)
            clbs_pkg::ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
            end
            clbs_pkg::ST_RUN: begin
                cmd.emit = stat.out_free;
                if (stat.kind == clbs_pkg::K_WAIT) begin
                    cmd.wait_ph = 1'b1;
                    cmd.hold    = stat.wait_hold;
                    step_end    = 1'b1;
                end else begin
                    cmd.en   = (sub_reg == 2'd1);
                    cmd.hold = (sub_reg == 2'd2) ? clbs_pkg::H_100 : clbs_pkg::H_1;
                    // a nibble-mode byte strobes twice before it ends
                    byte_end = (sub_reg == 2'd2) &&
                               !(stat.kind == clbs_pkg::K_BYTE && stat.four_bit && !nib_reg);
                    go_extra = byte_end && stat.kind == clbs_pkg::K_BYTE && stat.needs_extra;
                    step_end = byte_end && !go_extra;
                end
                cmd.last = step_end && stat.last_step;
            end
            clbs_pkg::ST_EXTRA: begin
                cmd.emit    = stat.out_free;
                cmd.wait_ph = 1'b1;
                cmd.hold    = clbs_pkg::H_2000;
                step_end    = 1'b1;
                cmd.last    = stat.last_step;
            end
            default: ;
        endcase
    end

    always_comb begin
        step_next = step_reg;
        sub_next  = sub_reg;
        nib_next  = nib_reg;
        if (cmd.start) begin
            step_next = '0;
            sub_next  = '0;
            nib_next  = 1'b0;
        end else if (cmd.emit) begin
            if (step_end) begin
                step_next = step_reg + 1'b1;
                sub_next  = '0;
                nib_next  = 1'b0;
            end else if (go_extra) begin
                sub_next = '0;
            end else if (sub_reg == 2'd2) begin
                sub_next = '0;
                nib_next = 1'b1;
            end else begin
                sub_next = sub_reg + 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            clbs_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = clbs_pkg::ST_RUN;
            end
            clbs_pkg::ST_RUN: begin
                if (cmd.emit) begin
                    if (step_end && stat.last_step) state_next = clbs_pkg::ST_IDLE;
                    else if (go_extra)              state_next = clbs_pkg::ST_EXTRA;
                end
            end
            clbs_pkg::ST_EXTRA: begin
                if (cmd.emit) begin
                    state_next = stat.last_step ? clbs_pkg::ST_IDLE : clbs_pkg::ST_RUN;
                end
            end
            default: state_next = clbs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= clbs_pkg::ST_IDLE;
            step_reg  <= '0;
            sub_reg   <= '0;
            nib_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sub_reg   <= sub_next;
            nib_reg   <= nib_next;
        end
    end

endmodule

/* hw/rtl/clbs_datapath.sv */
`timescale 1ns / 1ps

module clbs_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [23:0]          s_tdata,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [5:0]           cfg_data,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [31:0]          m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast,
    input  clbs_pkg::clbs_cmd_t  cmd,
    output clbs_pkg::clbs_stat_t stat
);

    logic       four_bit_reg;
    logic [2:0] line_count_reg;
    logic [5:0] columns_reg;
    logic       tall_font_reg;

    clbs_pkg::op_t op_reg;
    logic [7:0]    req_byte_reg;
    logic [7:0]    req_byte_next;

    logic       run_rs_reg;
    logic [7:0] run_bus_reg;

    logic        out_valid_reg;
    logic        out_rs_reg;
    logic        out_en_reg;
    logic [7:0]  out_bus_reg;
    logic [15:0] out_hold_reg;
    logic        out_last_reg;

    clbs_pkg::op_t in_op;
    logic [7:0]    in_value;
    logic [5:0]    in_column;
    logic [1:0]    in_row;
    logic [2:0]    lines;
    logic [2:0]    row_clamped;
    logic [7:0]    row_offset;
    logic [7:0]    cursor_sum;
    logic [7:0]    fs_byte;
    clbs_pkg::step_desc_t desc;
    logic [7:0]    strobe_bus;
    logic          phase_rs;
    logic [7:0]    phase_bus;

    assign in_op     = clbs_pkg::op_t'(s_tdata[1:0]);
    assign in_value  = s_tdata[9:2];
    assign in_column = s_tdata[15:10];
    assign in_row    = s_tdata[17:16];

    // Cursor address: clamp the row to the line count, add the row offset
    always_comb begin
        lines       = (line_count_reg == 3'd0) ? 3'd1 : line_count_reg;
        row_clamped = ({1'b0, in_row} >= lines) ? lines - 3'd1 : {1'b0, in_row};
        unique case (row_clamped[1:0])
            2'd0:    row_offset = 8'h00;
            2'd1:    row_offset = clbs_pkg::ROW1_OFFSET;
            2'd2:    row_offset = {2'b00, columns_reg};
            2'd3:    row_offset = clbs_pkg::ROW1_OFFSET + {2'b00, columns_reg};
            default: row_offset = 8'h00;
        endcase
        cursor_sum    = {2'b00, in_column} + row_offset;
        req_byte_next = (in_op == clbs_pkg::OP_CURSOR)
                        ? (clbs_pkg::DDRAM_ADDR_CMD | cursor_sum) : in_value;
    end

    always_comb begin
        fs_byte = 8'h20;
        if (!four_bit_reg)                             fs_byte = fs_byte | 8'h10;
        if (line_count_reg > 3'd1)                     fs_byte = fs_byte | 8'h08;
        if (tall_font_reg && line_count_reg == 3'd1)   fs_byte = fs_byte | 8'h04;
    end

    always_comb begin
        if (op_reg == clbs_pkg::OP_INIT) begin
            desc = clbs_pkg::init_step(cmd.step, four_bit_reg, fs_byte);
        end else begin
            desc.kind      = clbs_pkg::K_BYTE;
            desc.rs        = (op_reg == clbs_pkg::OP_DATA);
            desc.data      = req_byte_reg;
            desc.wait_hold = clbs_pkg::H_2000;
        end
    end

    always_comb begin
        stat.kind        = desc.kind;
        stat.wait_hold   = desc.wait_hold;
        stat.needs_extra = !desc.rs && desc.data >= 8'h01 && desc.data <= 8'h03;
        stat.four_bit    = four_bit_reg;
        stat.out_free    = !out_valid_reg || m_tready;
        if (op_reg == clbs_pkg::OP_INIT) begin
            stat.last_step = four_bit_reg
                ? (cmd.step == clbs_pkg::LAST_INIT_STEP_NIBBLE)
                : (cmd.step == clbs_pkg::LAST_INIT_STEP_BYTE);
        end else begin
            stat.last_step = 1'b1;
        end
    end

    always_comb begin
        if (desc.kind == clbs_pkg::K_BYTE && four_bit_reg) begin
            strobe_bus = cmd.nib ? {desc.data[3:0], 4'h0} : {desc.data[7:4], 4'h0};
        end else begin
            strobe_bus = desc.data;
        end
        // wait phases keep RS and the bus of the phase before
        phase_rs  = cmd.wait_ph ? run_rs_reg  : desc.rs;
        phase_bus = cmd.wait_ph ? run_bus_reg : strobe_bus;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            four_bit_reg   <= 1'b1;
            line_count_reg <= 3'd2;
            columns_reg    <= 6'd16;
            tall_font_reg  <= 1'b0;
        end else if (cfg_valid) begin
            unique case (clbs_pkg::cfg_idx_t'(cfg_index))
                clbs_pkg::CFG_FOUR_BIT:   four_bit_reg   <= cfg_data[0];
                clbs_pkg::CFG_LINE_COUNT: line_count_reg <= cfg_data[2:0];
                clbs_pkg::CFG_COLUMNS:    columns_reg    <= cfg_data;
                clbs_pkg::CFG_TALL_FONT:  tall_font_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg      <= clbs_pkg::OP_COMMAND;
            run_rs_reg  <= 1'b0;
            run_bus_reg <= 8'h00;
        end else if (cmd.start) begin
            op_reg      <= in_op;
            run_rs_reg  <= 1'b0;
            run_bus_reg <= 8'h00;
        end else if (cmd.emit && !cmd.wait_ph) begin
            run_rs_reg  <= phase_rs;
            run_bus_reg <= phase_bus;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            req_byte_reg <= req_byte_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_rs_reg   <= phase_rs;
            out_en_reg   <= cmd.en;
            out_bus_reg  <= phase_bus;
            out_hold_reg <= clbs_pkg::hold_value(cmd.hold);
            out_last_reg <= cmd.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_hold_reg, out_bus_reg, out_en_reg, 1'b0};
    assign m_tuser  = out_rs_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* hw/rtl/char_lcd_bus_sequencer_unit.sv */
`timescale 1ns / 1ps

// Character display bus sequencer.
// s_ channel: one request per item (operation, value, column, row). Each
// request expands into a run of bus phases on the m_ channel, one item per
// phase, with m_tlast on the final phase of the run. m_tuser carries RS;
// m_tdata carries RW, EN, the bus byte and the hold time in microseconds.
// cfg_ channel: register writes, always ready; write only while idle.
// After a request is taken, the controller enters its run state and loads the
// first phase into the output register. One phase per cycle while m_tready is
// high; the phase counter in the controller steps through the phases of a run.
// s_tready is high only between runs.
// A stall on m_tready holds the output register and freezes the sequencer.
// Reset clears the run and restores nibble mode, two lines, 16 columns and
// the normal font.
module char_lcd_bus_sequencer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // operation[1:0], value[9:2], column[15:10], row[17:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // rw_level[0], enable_level[1], bus_data[9:2], hold_us[25:10]
    output logic        m_tuser,   // rs_level[0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data
);

    clbs_pkg::clbs_cmd_t  cmd;
    clbs_pkg::clbs_stat_t stat;

    assign cfg_ready = 1'b1;

    clbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    clbs_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

/* hw/rtl/clbs_checker.sv */
`timescale 1ns / 1ps

module clbs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // hold a stalled item
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled item changed");

    a_write_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[0] == 1'b0 && m_tdata[31:26] == 6'd0)
        else $error("rw level or padding set");

    a_strobe_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[25:10] == 16'd1 && !m_tlast)
        else $error("enable high phase with wrong hold or as last");

    a_busy_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("request taken in the middle of a run");

endmodule

bind char_lcd_bus_sequencer_unit clbs_checker u_clbs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* bench/tb_char_lcd_bus_sequencer_unit.sv */
`timescale 1ns / 1ps

module tb_char_lcd_bus_sequencer_unit;

    localparam int unsigned CYCLE_LIMIT   = 10000000;
    localparam int unsigned PHASES_RANDOM = 8;
    localparam int unsigned ITEMS_PER_PH  = 48;

    localparam logic [15:0] HOLD_EDGE   = 16'd1;
    localparam logic [15:0] HOLD_SETTLE = 16'd100;
    localparam logic [15:0] HOLD_SHORT  = 16'd150;
    localparam logic [15:0] HOLD_CLEAR  = 16'd2000;
    localparam logic [15:0] HOLD_WAKE   = 16'd4500;
    localparam logic [15:0] HOLD_POWER  = 16'd50000;

    localparam logic [7:0] FS_BASE     = 8'h20;
    localparam logic [7:0] FS_EIGHT    = 8'h10;
    localparam logic [7:0] FS_TWO_LINE = 8'h08;
    localparam logic [7:0] FS_TALL     = 8'h04;
    localparam logic [7:0] CMD_WAIT_LO = 8'h01;
    localparam logic [7:0] CMD_WAIT_HI = 8'h03;

    typedef struct packed {
        clbs_pkg::op_t op;
        logic [7:0]    value;
        logic [5:0]    column;
        logic [1:0]    row;
    } lcd_req_t;

    typedef struct packed {
        logic        rs;
        logic        rw;
        logic        en;
        logic [7:0]  bus;
        logic [15:0] hold;
        logic        last;
    } bus_phase_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [5:0]  cfg_data  = '0;

    char_lcd_bus_sequencer_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow of the block's registers
    logic       mdl_four_bit = 1'b1;
    logic [2:0] mdl_lines    = 3'd2;
    logic [5:0] mdl_columns  = 6'd16;
    logic       mdl_tall     = 1'b0;

    logic       run_rs;
    logic [7:0] run_bus;

    lcd_req_t   req_pending_q[$];
    bus_phase_t run_phases[$];
    bus_phase_t phase_due_q[$];

    int unsigned errors = 0;
    int unsigned cycles = 0;
    bit          calm   = 1'b0;

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic push_phase(input logic en, input logic [15:0] hold);
        bus_phase_t p;
        p.rs   = run_rs;
        p.rw   = 1'b0;
        p.en   = en;
        p.bus  = run_bus;
        p.hold = hold;
        p.last = 1'b0;
        run_phases.push_back(p);
    endtask

    task automatic strobe_bus(input logic [7:0] bus);
        run_bus = bus;
        push_phase(1'b0, HOLD_EDGE);
        push_phase(1'b1, HOLD_EDGE);
        push_phase(1'b0, HOLD_SETTLE);
    endtask

    task automatic send_byte(input logic [7:0] v, input logic rs);
        run_rs = rs;
        if (mdl_four_bit) begin
            strobe_bus({v[7:4], 4'h0});
            strobe_bus({v[3:0], 4'h0});
        end else begin
            strobe_bus(v);
        end
    endtask

    task automatic send_command(input logic [7:0] v);
        send_byte(v, 1'b0);
        if (v >= CMD_WAIT_LO && v <= CMD_WAIT_HI)
            push_phase(1'b0, HOLD_CLEAR);
    endtask

    task automatic power_up_script();
        logic [7:0] fs;
        fs = FS_BASE;
        if (!mdl_four_bit)
            fs = fs | FS_EIGHT;
        if (mdl_lines > 3'd1)
            fs = fs | FS_TWO_LINE;
        if (mdl_tall && mdl_lines == 3'd1)
            fs = fs | FS_TALL;
        run_rs  = 1'b0;
        run_bus = 8'h00;
        push_phase(1'b0, HOLD_POWER);
        if (mdl_four_bit) begin
            strobe_bus(clbs_pkg::NIB_WAKE);
            push_phase(1'b0, HOLD_WAKE);
            strobe_bus(clbs_pkg::NIB_WAKE);
            push_phase(1'b0, HOLD_WAKE);
            strobe_bus(clbs_pkg::NIB_WAKE);
            push_phase(1'b0, HOLD_SHORT);
            strobe_bus(clbs_pkg::NIB_FOUR_BIT);
        end else begin
            send_command(fs);
            push_phase(1'b0, HOLD_WAKE);
            send_command(fs);
            push_phase(1'b0, HOLD_SHORT);
            send_command(fs);
        end
        send_command(fs);
        send_command(clbs_pkg::CMD_DISPLAY_ON);
        send_command(clbs_pkg::CMD_CLEAR);
        send_command(clbs_pkg::CMD_ENTRY_MODE);
    endtask

    task automatic cursor_command(input logic [5:0] col, input logic [1:0] row);
        logic [2:0] lines;
        logic [1:0] r;
        logic [7:0] offset;
        logic [7:0] addr;
        lines = (mdl_lines == 3'd0) ? 3'd1 : mdl_lines;
        r = row;
        if ({1'b0, r} >= lines)
            r = 2'(lines - 3'd1);
        case (r)
            2'd0:    offset = 8'h00;
            2'd1:    offset = clbs_pkg::ROW1_OFFSET;
            2'd2:    offset = {2'b00, mdl_columns};
            default: offset = clbs_pkg::ROW1_OFFSET + {2'b00, mdl_columns};
        endcase
        // address is summed in 8 bits before the DDRAM bit goes in
        addr = {2'b00, col} + offset;
        send_command(clbs_pkg::DDRAM_ADDR_CMD | addr);
    endtask

    task automatic expand_request(input lcd_req_t req);
        bus_phase_t p;
        run_phases.delete();
        case (req.op)
            clbs_pkg::OP_COMMAND: send_command(req.value);
            clbs_pkg::OP_DATA:    send_byte(req.value, 1'b1);
            clbs_pkg::OP_INIT:    power_up_script();
            default:              cursor_command(req.column, req.row);
        endcase
        for (int i = 0; i < run_phases.size(); i++) begin
            p = run_phases[i];
            p.last = (i == run_phases.size() - 1);
            phase_due_q.push_back(p);
        end
    endtask

    // Request driver
    lcd_req_t    drv_cur;
    int unsigned drv_gap = 0;
    logic        drv_busy;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            drv_gap  = 0;
        end else begin
            drv_busy = s_tvalid;
            if (s_tvalid && s_tready) begin
                expand_request(drv_cur);
                drv_busy = 1'b0;
            end
            if (!drv_busy) begin
                if (drv_gap > 0) begin
                    drv_gap = drv_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (req_pending_q.size() > 0) begin
                    drv_cur = req_pending_q.pop_front();
                    s_tdata <= {6'd0, drv_cur.row, drv_cur.column, drv_cur.value, drv_cur.op};
                    s_tvalid <= 1'b1;
                    drv_gap = idle_len();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors = errors + 1;
        end
    endtask

    // Phase monitor
    int unsigned mon_stall = 0;
    bus_phase_t  mon_want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            mon_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (phase_due_q.size() == 0) begin
                    $display("%0t: phase with none due: expected nothing, actual %h rs %b last %b",
                             $time, m_tdata, m_tuser, m_tlast);
                    errors = errors + 1;
                end else begin
                    mon_want = phase_due_q.pop_front();
                    check_field("rs_level", 16'(mon_want.rs), 16'(m_tuser));
                    check_field("rw_level", 16'(mon_want.rw), 16'(m_tdata[0]));
                    check_field("enable_level", 16'(mon_want.en), 16'(m_tdata[1]));
                    check_field("bus_data", 16'(mon_want.bus), 16'(m_tdata[9:2]));
                    check_field("hold_us", mon_want.hold, m_tdata[25:10]);
                    check_field("last", 16'(mon_want.last), 16'(m_tlast));
                end
            end
            if (mon_stall > 0) begin
                mon_stall = mon_stall - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                mon_stall = idle_len();
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic queue_req(input clbs_pkg::op_t op, input logic [7:0] value,
                             input logic [5:0] column, input logic [1:0] row);
        lcd_req_t r;
        r.op     = op;
        r.value  = value;
        r.column = column;
        r.row    = row;
        req_pending_q.push_back(r);
    endtask

    // Hold until every item is taken and every phase has come out
    task automatic wait_idle();
        while (req_pending_q.size() > 0 || s_tvalid || phase_due_q.size() > 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic cfg_write(input clbs_pkg::cfg_idx_t idx, input logic [5:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            clbs_pkg::CFG_FOUR_BIT:   mdl_four_bit = data[0];
            clbs_pkg::CFG_LINE_COUNT: mdl_lines    = data[2:0];
            clbs_pkg::CFG_COLUMNS:    mdl_columns  = data;
            default:                  mdl_tall     = data[0];
        endcase
    endtask

    task automatic cfg_all(input logic four, input logic [2:0] lines,
                           input logic [5:0] cols, input logic tall);
        wait_idle();
        cfg_write(clbs_pkg::CFG_FOUR_BIT, {5'd0, four});
        cfg_write(clbs_pkg::CFG_LINE_COUNT, {3'd0, lines});
        cfg_write(clbs_pkg::CFG_COLUMNS, cols);
        cfg_write(clbs_pkg::CFG_TALL_FONT, {5'd0, tall});
    endtask

    function automatic logic [2:0] pick_lines();
        case ($urandom_range(0, 5))
            0:       return 3'd0;
            1:       return 3'd1;
            2:       return 3'd4;
            3:       return 3'd7;
            default: return 3'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [5:0] pick_columns();
        case ($urandom_range(0, 5))
            0:       return 6'd0;
            1:       return 6'd1;
            2:       return 6'd40;
            3:       return 6'd63;
            default: return 6'($urandom_range(0, 63));
        endcase
    endfunction

    initial begin : stimulus
        int unsigned   r;
        clbs_pkg::op_t op;
        logic [7:0]    value;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: nibble mode, two lines, 16 columns
        queue_req(clbs_pkg::OP_COMMAND, 8'h00, 6'd0, 2'd0);
        queue_req(clbs_pkg::OP_COMMAND, 8'h01, 6'd0, 2'd0);
        queue_req(clbs_pkg::OP_COMMAND, 8'h02, 6'd63, 2'd3);
        queue_req(clbs_pkg::OP_COMMAND, 8'h03, 6'd0, 2'd0);
        queue_req(clbs_pkg::OP_COMMAND, 8'h04, 6'd0, 2'd0);
        queue_req(clbs_pkg::OP_COMMAND, 8'hFF, 6'd0, 2'd0);
        queue_req(clbs_pkg::OP_DATA, 8'h00, 6'd0, 2'd0);
        queue_req(clbs_pkg::OP_DATA, 8'hFF, 6'd63, 2'd3);
        queue_req(clbs_pkg::OP_DATA, 8'hA5, 6'd0, 2'd0);
        queue_req(clbs_pkg::OP_INIT, 8'h00, 6'd0, 2'd0);
        queue_req(clbs_pkg::OP_CURSOR, 8'h00, 6'd0, 2'd0);
        queue_req(clbs_pkg::OP_CURSOR, 8'hFF, 6'd63, 2'd3);
        queue_req(clbs_pkg::OP_CURSOR, 8'h00, 6'd39, 2'd1);
        queue_req(clbs_pkg::OP_CURSOR, 8'h00, 6'd5, 2'd2);

        // 8-bit bus, one line, tall font honored
        cfg_all(1'b0, 3'd1, 6'd40, 1'b1);
        queue_req(clbs_pkg::OP_INIT, 8'h00, 6'd0, 2'd0);
        queue_req(clbs_pkg::OP_COMMAND, 8'h01, 6'd0, 2'd0);
        queue_req(clbs_pkg::OP_DATA, 8'h5A, 6'd0, 2'd0);
        queue_req(clbs_pkg::OP_CURSOR, 8'h00, 6'd39, 2'd3);

        // zero lines acts as one line, without the font bits
        cfg_all(1'b1, 3'd0, 6'd20, 1'b1);
        queue_req(clbs_pkg::OP_INIT, 8'h00, 6'd0, 2'd0);
        queue_req(clbs_pkg::OP_CURSOR, 8'h00, 6'd10, 2'd2);

        // oversized offset is summed in 8 bits before the DDRAM bit
        cfg_all(1'b0, 3'd7, 6'd63, 1'b0);
        queue_req(clbs_pkg::OP_CURSOR, 8'h00, 6'd63, 2'd3);
        queue_req(clbs_pkg::OP_CURSOR, 8'h00, 6'd63, 2'd2);
        queue_req(clbs_pkg::OP_INIT, 8'h00, 6'd0, 2'd0);

        for (int ph = 0; ph < PHASES_RANDOM; ph++) begin
            case (ph)
                0:       cfg_all(1'b0, 3'd1, 6'd0, 1'b1);
                1:       cfg_all(1'b1, 3'd4, 6'd40, 1'b0);
                2:       cfg_all(1'b1, 3'd7, 6'd63, 1'b1);
                default: cfg_all(1'($urandom_range(0, 1)), pick_lines(), pick_columns(),
                                 1'($urandom_range(0, 1)));
            endcase
            calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < ITEMS_PER_PH; k++) begin
                if (k == ITEMS_PER_PH / 2)
                    wait_idle();
                r = $urandom_range(0, 99);
                if (r < 4)
                    op = clbs_pkg::OP_INIT;
                else if (r < 40)
                    op = clbs_pkg::OP_COMMAND;
                else if (r < 70)
                    op = clbs_pkg::OP_DATA;
                else
                    op = clbs_pkg::OP_CURSOR;
                // favor the codes that add the clear wait
                if (op == clbs_pkg::OP_COMMAND && $urandom_range(0, 3) == 0)
                    value = 8'($urandom_range(0, 4));
                else
                    value = 8'($urandom_range(0, 255));
                queue_req(op, value, 6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)));
                if ($urandom_range(0, 7) == 0)
                    @(posedge aclk);
            end
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        if (errors == 0 && phase_due_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/clbs_pkg.sv
hw/rtl/clbs_ctrl.sv
hw/rtl/clbs_datapath.sv
hw/rtl/char_lcd_bus_sequencer_unit.sv
hw/rtl/clbs_checker.sv
bench/tb_char_lcd_bus_sequencer_unit.sv
